### rtl/light_box_cull_mask_top_assert.svh
// ----------------------------------------------------------------------------
// Light box cull mask assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LIGHT_BOX_CULL_MASK_TOP_ASSERT_SVH
`define LIGHT_BOX_CULL_MASK_TOP_ASSERT_SVH

// same-cycle implication
`define LBCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lbcm_pkg.sv
// ----------------------------------------------------------------------------
// Light box cull mask package
// Commands, register indexes, field widths and shared types.
// ----------------------------------------------------------------------------
package lbcm_pkg;

	localparam int IDX_W  = 5;
	localparam int MASK_W = 32;
	localparam int RAD_W  = 31;
	localparam int CNT_W  = 6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_LIGHT_COUNT = 1'b0;
	localparam logic REG_TOUCH_MODE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// tag that travels with one light test down the pipeline
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

### rtl/light_box_cull_mask_top.sv
// Throughput: one light per cycle from the light memory read port; one query at a time,
// the input stays stalled until its mask is posted and reopens as out_valid presents it.
// Writes to the light table are accepted back to back while no query is in flight.
// Reset clears control, registers and out_valid; light entries are undefined until written.
// ----------------------------------------------------------------------------
// Light box cull mask top
// Stores lights in a table and culls them against a query box, one per cycle.
// ----------------------------------------------------------------------------
module light_box_cull_mask_top #(
	parameter int MAX_LIGHTS  = 32,
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [4:0]  light_index,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [30:0] light_radius_in,
	input  logic [31:0] query_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] surviving_mask
);

	localparam int CW   = COORD_WIDTH;
	localparam int EXT  = (CW > 32) ? CW : 32;
	localparam int AW   = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CNTW = $clog2(MAX_LIGHTS + 1);
	localparam int DW   = 3*CW + lbcm_pkg::RAD_W;

	function automatic logic signed [CW-1:0] to_coord(input logic signed [31:0] v);
		logic signed [EXT-1:0] e;
		e = EXT'(v);
		return signed'(e[CW-1:0]);
	endfunction

	lbcm_pkg::state_t state_q;
	logic [lbcm_pkg::CNT_W-1:0]  light_count_q;
	logic                        touch_q;
	logic [CNTW-1:0]             cnt_q;
	logic [CNTW-1:0]             iss_q;
	logic [CNTW-1:0]             eff_cnt;
	logic [lbcm_pkg::MASK_W-1:0] qmask_q;
	logic [lbcm_pkg::MASK_W-1:0] acc_q;
	logic [lbcm_pkg::MASK_W-1:0] out_q;
	logic                        out_vld_q;
	logic signed [CW-1:0]        box_min_q [3];
	logic signed [CW-1:0]        box_max_q [3];

	logic                        in_acc;
	logic                        wr_en;
	logic                        issue;
	logic                        out_free;
	logic [DW-1:0]               wdata;
	logic [DW-1:0]               rdata;
	lbcm_pkg::tag_t              tag_s1;
	lbcm_pkg::tag_t              tag_s3;
	logic                        hit_s3;
	logic                        busy;

	assign in_stall = (state_q != lbcm_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = in_acc && (cmd == lbcm_pkg::CMD_WRITE)
		&& (32'(light_index) < MAX_LIGHTS);
	assign issue    = (state_q == lbcm_pkg::ST_SCAN) && (iss_q < cnt_q);
	assign out_free = !out_vld_q || !out_stall;
	assign eff_cnt  = (32'(light_count_q) > MAX_LIGHTS) ? CNTW'(MAX_LIGHTS)
		: CNTW'(light_count_q);
	assign wdata    = {to_coord(a_z), to_coord(a_y), to_coord(a_x), light_radius_in};

	lbcm_light_mem #(
		.DEPTH (MAX_LIGHTS),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (light_index[AW-1:0]),
		.wdata (wdata),
		.re    (issue),
		.raddr (iss_q[AW-1:0]),
		.rdata (rdata)
	);

	lbcm_cull_unit #(
		.CW (CW)
	) u_cull (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.ent_s1    (rdata),
		.box_min   (box_min_q),
		.box_max   (box_max_q),
		.inclusive (touch_q),
		.tag_s3    (tag_s3),
		.hit_s3    (hit_s3),
		.busy      (busy)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_count_q <= '0;
			touch_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbcm_pkg::REG_LIGHT_COUNT: light_count_q <= cfg_data;
				lbcm_pkg::REG_TOUCH_MODE:  touch_q       <= cfg_data[0];
				default:                   light_count_q <= light_count_q;
			endcase
		end
	end

	// query payload
	always_ff @(posedge clk) begin
		if (in_acc && (cmd == lbcm_pkg::CMD_QUERY)) begin
			box_min_q[0] <= to_coord(a_x);
			box_min_q[1] <= to_coord(a_y);
			box_min_q[2] <= to_coord(a_z);
			box_max_q[0] <= to_coord(b_x);
			box_max_q[1] <= to_coord(b_y);
			box_max_q[2] <= to_coord(b_z);
			qmask_q      <= query_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbcm_pkg::ST_DONE && out_free) begin
			out_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lbcm_pkg::ST_IDLE;
			cnt_q     <= '0;
			iss_q     <= '0;
			acc_q     <= '0;
			tag_s1    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// unmasked lights never enter the pipeline
			tag_s1.vld <= issue && qmask_q[iss_q[AW-1:0]];
			tag_s1.idx <= lbcm_pkg::IDX_W'(iss_q[AW-1:0]);
			if (tag_s3.vld && hit_s3) begin
				acc_q[tag_s3.idx] <= 1'b1;
			end
			if ((state_q == lbcm_pkg::ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				lbcm_pkg::ST_IDLE: begin
					if (in_acc && (cmd == lbcm_pkg::CMD_QUERY)) begin
						cnt_q   <= eff_cnt;
						iss_q   <= '0;
						acc_q   <= '0;
						state_q <= lbcm_pkg::ST_SCAN;
					end
				end
				lbcm_pkg::ST_SCAN: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end else if (!tag_s1.vld && !busy) begin
						state_q <= lbcm_pkg::ST_DONE;
					end
				end
				lbcm_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= lbcm_pkg::ST_IDLE;
					end
				end
				default: state_q <= lbcm_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_vld_q;
	assign surviving_mask = out_q;

endmodule

### rtl/lbcm_light_mem.sv
// ----------------------------------------------------------------------------
// Light table memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbcm_light_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 127
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/lbcm_cull_unit.sv
// ----------------------------------------------------------------------------
// Light cull unit
// Two-stage cube/box overlap test on one light entry per cycle.
// ----------------------------------------------------------------------------
module lbcm_cull_unit #(
	parameter int CW = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lbcm_pkg::tag_t           tag_s1,
	input  logic [3*CW+lbcm_pkg::RAD_W-1:0] ent_s1,
	input  logic signed [CW-1:0]     box_min [3],
	input  logic signed [CW-1:0]     box_max [3],
	input  logic                     inclusive,
	output lbcm_pkg::tag_t           tag_s3,
	output logic                     hit_s3,
	output logic                     busy
);

	localparam int EXT = (CW > 32) ? CW : 32;
	localparam int EW  = EXT + 1;

	logic signed [CW-1:0] cen [3];
	logic signed [EW-1:0] rad_e;
	logic signed [EW-1:0] hi_s2 [3];
	logic signed [EW-1:0] lo_s2 [3];
	logic signed [EW-1:0] mn_e [3];
	logic signed [EW-1:0] mx_e [3];
	logic [2:0]           miss;
	lbcm_pkg::tag_t       tag_s2;

	always_comb begin
		rad_e = signed'({{(EW-lbcm_pkg::RAD_W){1'b0}}, ent_s1[lbcm_pkg::RAD_W-1:0]});
		for (int a = 0; a < 3; a++) begin
			cen[a] = signed'(ent_s1[lbcm_pkg::RAD_W + a*CW +: CW]);
		end
	end

	// stage 2: cube extent per axis
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			hi_s2[a] <= EW'(cen[a]) + rad_e;
			lo_s2[a] <= EW'(cen[a]) - rad_e;
		end
	end

	// stage 3: compare against the box
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mn_e[a] = EW'(box_min[a]);
			mx_e[a] = EW'(box_max[a]);
			if (inclusive) begin
				miss[a] = (hi_s2[a] < mn_e[a]) || (lo_s2[a] > mx_e[a]);
			end else begin
				miss[a] = (hi_s2[a] <= mn_e[a]) || (lo_s2[a] >= mx_e[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s3 <= ~|miss;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign busy = tag_s2.vld | tag_s3.vld;

endmodule

### rtl/lbcm_checker.sv
// ----------------------------------------------------------------------------
// Light box cull mask port checker
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
`include "light_box_cull_mask_top_assert.svh"

module lbcm_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic cmd,
	input logic out_valid,
	input logic out_stall
);

	`LBCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`LBCM_ASSERT_NEXT(a_query_blocks, clk, arst_n, in_valid && !in_stall && (cmd == lbcm_pkg::CMD_QUERY), in_stall, "query did not block input")
	`LBCM_ASSERT_NEXT(a_write_single, clk, arst_n, in_valid && !in_stall && (cmd == lbcm_pkg::CMD_WRITE), !in_stall, "light write blocked input")
	`LBCM_ASSERT_IMPL(a_result_from_query, clk, arst_n, $rose(out_valid), $past(in_stall), "result without a query in flight")

endmodule

bind light_box_cull_mask_top lbcm_port_checker u_lbcm_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

### verif/lbcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light box cull mask checker
// Watches the register port and both request channels, keeps its own copy of
// the light table and registers, predicts each query's surviving mask, and
// compares it with the mask the block returns, oldest first.
// ----------------------------------------------------------------------------
module lbcm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic [4:0]         light_index,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [30:0]        light_radius_in,
	input  logic [31:0]        query_mask,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [31:0]        surviving_mask,
	output int                 fail_count,
	output int                 masks_owed,
	output int                 writes_seen,
	output int                 queries_seen,
	output int                 hits_seen
);

	localparam int NUM_LIGHTS = 32;

	logic [lbcm_pkg::CNT_W-1:0]  active_count;
	logic                        inclusive;
	logic signed [31:0]          ctr_x [NUM_LIGHTS];
	logic signed [31:0]          ctr_y [NUM_LIGHTS];
	logic signed [31:0]          ctr_z [NUM_LIGHTS];
	logic [lbcm_pkg::RAD_W-1:0]  rad [NUM_LIGHTS];
	logic [lbcm_pkg::MASK_W-1:0] owed_masks [$];

	// cube of half-width r around c against [box_lo, box_hi] on one axis
	function automatic bit axis_overlap(input longint c, input longint r,
		input longint box_lo, input longint box_hi, input bit incl);
		longint hi;
		longint lo;
		hi = c + r;
		lo = c - r;
		if (incl)
			return !(hi < box_lo || lo > box_hi);
		return !(hi <= box_lo || lo >= box_hi);
	endfunction

	function automatic logic [lbcm_pkg::MASK_W-1:0] surviving_lights(
		input logic signed [31:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z,
		input logic [lbcm_pkg::MASK_W-1:0] qmask);
		int n;
		int i;
		longint r;
		logic [lbcm_pkg::MASK_W-1:0] hits;
		n = (active_count > NUM_LIGHTS) ? NUM_LIGHTS : int'(active_count);
		hits = '0;
		for (i = 0; i < n; i++) begin
			if (!qmask[i])
				continue;
			r = longint'(rad[i]);
			if (axis_overlap(longint'(ctr_x[i]), r, longint'(mn_x), longint'(mx_x), inclusive) &&
			    axis_overlap(longint'(ctr_y[i]), r, longint'(mn_y), longint'(mx_y), inclusive) &&
			    axis_overlap(longint'(ctr_z[i]), r, longint'(mn_z), longint'(mx_z), inclusive))
				hits[i] = 1'b1;
		end
		return hits;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [lbcm_pkg::MASK_W-1:0] want_mask;
		if (!arst_n) begin
			active_count = '0;
			inclusive    = 1'b0;
			owed_masks.delete();
			fail_count   = 0;
			masks_owed   = 0;
			writes_seen  = 0;
			queries_seen = 0;
			hits_seen    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_masks.size() == 0) begin
					fail_count++;
					$display("%0t: surviving_mask with no query waiting: expected none, got %h",
						$time, surviving_mask);
				end else begin
					want_mask = owed_masks.pop_front();
					if (surviving_mask !== want_mask) begin
						fail_count++;
						$display("%0t: surviving_mask mismatch: expected %h, got %h",
							$time, want_mask, surviving_mask);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					lbcm_pkg::REG_LIGHT_COUNT: active_count = cfg_data;
					lbcm_pkg::REG_TOUCH_MODE:  inclusive = cfg_data[0];
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == lbcm_pkg::CMD_WRITE) begin
					ctr_x[light_index] = a_x;
					ctr_y[light_index] = a_y;
					ctr_z[light_index] = a_z;
					rad[light_index]   = light_radius_in;
					writes_seen++;
				end else begin
					want_mask = surviving_lights(a_x, a_y, a_z, b_x, b_y, b_z, query_mask);
					owed_masks.push_back(want_mask);
					queries_seen++;
					if (want_mask != '0)
						hits_seen++;
				end
			end
			masks_owed = owed_masks.size();
		end
	end

endmodule

### verif/tb_light_box_cull_mask_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light box cull mask testbench
// Loads lights and sends box queries under several count and touch settings,
// with random gaps and stalls on both channels and one long output hold-off.
// A separate checker predicts every surviving mask and counts mismatches.
// ----------------------------------------------------------------------------
module tb_light_box_cull_mask_top;

	localparam int NUM_LIGHTS   = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE       = 45;
	localparam int PHASE_ITEMS  = 240;
	localparam logic signed [31:0] C_MIN = 32'h8000_0000;
	localparam logic signed [31:0] C_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic               cmd;
		logic [4:0]         idx;
		logic signed [31:0] ax, ay, az;
		logic signed [31:0] bx, by, bz;
		logic [30:0]        rad;
		logic [31:0]        qmask;
	} cull_req_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [5:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [4:0]         light_index;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic [30:0]        light_radius_in;
	logic [31:0]        query_mask;
	logic               out_valid;
	logic               out_stall;
	logic [31:0]        surviving_mask;

	int fail_count, masks_owed, writes_seen, queries_seen, hits_seen;
	int idle_cycles;
	int settings_run;
	int cur_count;
	bit quiet;
	bit hold_req;
	bit hold_done;

	// stimulus-side copy of the table, used only to aim boxes at lights
	logic signed [31:0] stim_x [NUM_LIGHTS];
	logic signed [31:0] stim_y [NUM_LIGHTS];
	logic signed [31:0] stim_z [NUM_LIGHTS];
	logic [30:0]        stim_r [NUM_LIGHTS];
	logic [31:0]        written;

	light_box_cull_mask_top DUT (.*);

	lbcm_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls, a quiet stretch, and one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 10);
			end
		end
	end

	function automatic cull_req_t light_write(input logic [4:0] idx,
		input logic signed [31:0] x, y, z, input logic [30:0] rad);
		cull_req_t r;
		r.cmd   = lbcm_pkg::CMD_WRITE;
		r.idx   = idx;
		r.ax    = x;
		r.ay    = y;
		r.az    = z;
		r.bx    = $urandom;
		r.by    = $urandom;
		r.bz    = $urandom;
		r.rad   = rad;
		r.qmask = $urandom;
		return r;
	endfunction

	function automatic cull_req_t box_query(input logic signed [31:0] lx, ly, lz, hx, hy, hz,
		input logic [31:0] qm);
		cull_req_t r;
		r.cmd   = lbcm_pkg::CMD_QUERY;
		r.idx   = 5'($urandom);
		r.ax    = lx;
		r.ay    = ly;
		r.az    = lz;
		r.bx    = hx;
		r.by    = hy;
		r.bz    = hz;
		r.rad   = 31'($urandom);
		r.qmask = qm;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_coord();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return int'($urandom_range(0, 8191)) - 4096;
		if (sel < 90)
			return int'($urandom_range(0, 2097151)) - 1048576;
		return $urandom;
	endfunction

	function automatic logic [30:0] pick_radius();
		int sel;
		logic [31:0] raw;
		sel = $urandom_range(0, 99);
		raw = $urandom;
		if (sel < 70)
			return 31'($urandom_range(0, 2048));
		if (sel < 90)
			return 31'($urandom_range(0, 1 << 20));
		return raw[30:0];
	endfunction

	// mostly a sane span; sometimes two independent ends, inverted or not
	function automatic void pick_span(output logic signed [31:0] lo, hi);
		lo = pick_coord();
		if ($urandom_range(0, 99) < 80)
			hi = lo + int'($urandom_range(0, 4096));
		else
			hi = pick_coord();
	endfunction

	function automatic cull_req_t random_query();
		cull_req_t r;
		int i;
		logic signed [31:0] reach;
		r = box_query(0, 0, 0, 0, 0, 0, '1);
		pick_span(r.ax, r.bx);
		pick_span(r.ay, r.by);
		pick_span(r.az, r.bz);
		if ($urandom_range(0, 99) >= 70)
			r.qmask = $urandom;
		// put one box face exactly on a light's cube face
		i = $urandom_range(0, NUM_LIGHTS - 1);
		if ($urandom_range(0, 99) < 15 && written[i]) begin
			reach = $signed({1'b0, stim_r[i]});
			case ($urandom_range(0, 5))
				0: r.ax = stim_x[i] + reach;
				1: r.bx = stim_x[i] - reach;
				2: r.ay = stim_y[i] + reach;
				3: r.by = stim_y[i] - reach;
				4: r.az = stim_z[i] + reach;
				default: r.bz = stim_z[i] - reach;
			endcase
		end
		return r;
	endfunction

	task automatic offer_request(input cull_req_t r);
		logic [31:0] counted;
		counted = (cur_count >= NUM_LIGHTS) ? '1 : ((32'd1 << cur_count) - 32'd1);
		if (r.cmd == lbcm_pkg::CMD_QUERY)
			r.qmask &= written | ~counted;
		if (!quiet && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd             <= r.cmd;
		light_index     <= r.idx;
		a_x             <= r.ax;
		a_y             <= r.ay;
		a_z             <= r.az;
		b_x             <= r.bx;
		b_y             <= r.by;
		b_z             <= r.bz;
		light_radius_in <= r.rad;
		query_mask      <= r.qmask;
		in_valid        <= 1'b1;
		if (r.cmd == lbcm_pkg::CMD_WRITE) begin
			stim_x[r.idx] = r.ax;
			stim_y[r.idx] = r.ay;
			stim_z[r.idx] = r.az;
			stim_r[r.idx] = r.rad;
			written[r.idx] = 1'b1;
		end
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// wait for every owed mask, then let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (masks_owed != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_config(input logic [5:0] count, input logic mode);
		cfg_we    <= 1'b1;
		cfg_index <= lbcm_pkg::REG_LIGHT_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= lbcm_pkg::REG_TOUCH_MODE;
		cfg_data  <= {5'd0, mode};
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_count = count;
		settings_run++;
	endtask

	task automatic edge_queries();
		offer_request(box_query(-256, -256, -256, 256, 256, 256, '1));
		// touches light 0 on its +x face
		offer_request(box_query(256, -10, -10, 1000, 10, 10, '1));
		// touches light 3 on its -x face
		offer_request(box_query(0, -2000, 0, 900, 0, 1000, 32'h0000_0008));
		offer_request(box_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '1));
		offer_request(box_query(100, 100, 100, -100, -100, -100, '1));
		// degenerate box on the zero-radius light at the most negative corner
		offer_request(box_query(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, '1));
		offer_request(box_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0));
	endtask

	initial begin
		int p;
		int n;
		int i;
		logic [5:0] phase_count;
		logic phase_mode;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = lbcm_pkg::REG_LIGHT_COUNT;
		cfg_data        = '0;
		in_valid        = 1'b0;
		cmd             = lbcm_pkg::CMD_WRITE;
		light_index     = '0;
		a_x             = '0;
		a_y             = '0;
		a_z             = '0;
		b_x             = '0;
		b_y             = '0;
		b_z             = '0;
		light_radius_in = '0;
		query_mask      = '0;
		written         = '0;
		quiet           = 1'b0;
		hold_req        = 1'b0;
		hold_done       = 1'b0;
		settings_run    = 0;
		cur_count       = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extreme lights, touching faces, full and inverted boxes
		set_config(6'd4, 1'b0);
		offer_request(light_write(0, 0, 0, 0, 31'd256));
		offer_request(light_write(1, C_MAX, C_MAX, C_MAX, 31'h7fff_ffff));
		offer_request(light_write(2, C_MIN, C_MIN, C_MIN, 31'd0));
		offer_request(light_write(3, 1000, -1000, 500, 31'd100));
		offer_request(light_write(31, C_MAX, C_MIN, 0, 31'd1));
		edge_queries();
		drain();
		set_config(6'd4, 1'b1);
		edge_queries();

		for (p = 0; p < 7; p++) begin
			drain();
			case (p)
				0: begin phase_count = 6'd32; phase_mode = 1'b0; end
				1: begin phase_count = 6'd1;  phase_mode = 1'b1; end
				2: begin phase_count = 6'd17; phase_mode = 1'b0; end
				3: begin phase_count = 6'd63; phase_mode = 1'b1; end
				4: begin phase_count = 6'd0;  phase_mode = 1'b0; end
				5: begin phase_count = 6'd31; phase_mode = 1'b1; end
				default: begin
					phase_count = 6'($urandom_range(2, 30));
					phase_mode  = 1'($urandom_range(0, 1));
				end
			endcase
			set_config(phase_count, phase_mode);
			quiet = (p == 2);
			if (p == 0) begin
				hold_req = 1'b1;
				for (i = 0; i < NUM_LIGHTS; i++)
					offer_request(light_write(5'(i), pick_coord(), pick_coord(), pick_coord(),
						pick_radius()));
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 30)
					offer_request(light_write(5'($urandom), pick_coord(), pick_coord(),
						pick_coord(), pick_radius()));
				else
					offer_request(random_query());
			end
		end
		quiet = 1'b0;
		drain();

		$display("Run covered %0d light writes and %0d box queries (%0d with lights left)",
			writes_seen, queries_seen, hits_seen);
		$display("over %0d register settings, both touch modes, and a %0d-cycle output hold-off",
			settings_run, HOLD_CYCLES);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/lbcm_pkg.sv
rtl/lbcm_light_mem.sv
rtl/lbcm_cull_unit.sv
rtl/light_box_cull_mask_top.sv
rtl/lbcm_checker.sv
verif/lbcm_checker.sv
verif/tb_light_box_cull_mask_top.sv
